### rtl/text_console_writer_top_macros.svh
// assertion macros for the text console writer
// used by text_console_writer_top.sv; define SYNTH to compile them away
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge out of reset
`define TCW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcw assertion failed");

// expression must never be true out of reset
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("tcw forbidden condition seen");

`else

`define TCW_ASSERT(lbl, clk, rst_n, prop)
`define TCW_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### rtl/tcw_pkg.sv
// shared types and constants of the text console writer
// no dependencies; used by tcw_ctrl and text_console_writer_top
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int IN_ROW_W  = 5;
  localparam int IN_COL_W  = 7;
  localparam int CELL_W    = 16;

  localparam logic [7:0] NEWLINE_CODE      = 8'd10;
  localparam logic [7:0] SPACE_CODE        = 8'd32;
  localparam logic [7:0] TEXT_COLOR_RESET  = 8'd9;
  localparam logic [7:0] BLANK_COLOR_RESET = 8'd7;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR = 1'b1;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                command;
    logic [7:0]          char_code;
    logic [IN_ROW_W-1:0] cell_row;
    logic [IN_COL_W-1:0] cell_col;
  } tcw_in_t;

  typedef struct packed {
    logic [7:0]          cell_char;
    logic [7:0]          cell_attr;
    logic [IN_ROW_W-1:0] cursor_row;
    logic [IN_COL_W-1:0] cursor_col;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } tcw_state_e;

  typedef struct packed {
    logic clearing;
    logic scrolling;
    logic filling;
  } tcw_status_t;

endpackage

`default_nettype wire

### rtl/tcw_screen_ram.sv
// screen cell store: one write port, one registered read port
// no package dependencies
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int DATA_W = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/tcw_ctrl.sv
// sequencer of the text console writer: cursor, put/read, scroll copy,
// row fill and clearing pass over the screen store; uses tcw_pkg
`default_nettype none

module tcw_ctrl #(
  parameter int COLS = tcw_pkg::SCREEN_COLUMNS,
  parameter int ROWS = tcw_pkg::SCREEN_ROWS,
  localparam int CELL_COUNT = COLS * ROWS,
  localparam int ADDR_W = $clog2(CELL_COUNT)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire tcw_pkg::tcw_in_t           in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output tcw_pkg::tcw_out_t               out_req_o,
  input  wire logic [tcw_pkg::CFG_W-1:0]  text_color_i,
  input  wire logic [tcw_pkg::CFG_W-1:0]  blank_color_i,
  output logic                            ram_we_o,
  output logic [ADDR_W-1:0]               ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]      ram_wdata_o,
  output logic                            ram_re_o,
  output logic [ADDR_W-1:0]               ram_raddr_o,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata_i,
  output tcw_pkg::tcw_status_t            status_o
);

  localparam int CNT_W = $clog2(CELL_COUNT + 1);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  tcw_pkg::tcw_state_e state_q, state_d;
  logic [CNT_W-1:0]           ptr_q, ptr_d;
  logic [ADDR_W-1:0]          wr_addr_q, wr_addr_d;
  logic                       pend_q, pend_d;
  logic [ROW_W-1:0]           row_q, row_d;
  logic [COL_W-1:0]           col_q, col_d;
  logic [tcw_pkg::CELL_W-1:0] cell_q, cell_d;
  logic                       out_valid_q, out_valid_d;
  tcw_pkg::tcw_out_t          out_q, out_d;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_in_addr;
  logic              rd_in_range;
  logic              row_last, col_last, is_newline, wrap, need_scroll;
  logic              scan_done, fill_done, out_free;
  logic [31:0]       row_ext, col_ext;

  assign cur_addr    = ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(col_q);
  assign rd_in_addr  = ADDR_W'(in_req_i.cell_row) * ADDR_W'(COLS)
                     + ADDR_W'(in_req_i.cell_col);
  assign rd_in_range = (32'(in_req_i.cell_row) < 32'(ROWS))
                    && (32'(in_req_i.cell_col) < 32'(COLS));
  assign row_last    = (32'(row_q) == 32'(ROWS - 1));
  assign col_last    = (32'(col_q) == 32'(COLS - 1));
  assign is_newline  = (in_req_i.char_code == tcw_pkg::NEWLINE_CODE);
  assign wrap        = is_newline || col_last;
  assign need_scroll = wrap && row_last;
  assign scan_done   = (ptr_q == CNT_W'(CELL_COUNT));
  assign fill_done   = (ptr_q == CNT_W'(CELL_COUNT - 1));
  assign out_free    = !out_valid_q || out_ready_i;
  assign row_ext     = 32'(row_q);
  assign col_ext     = 32'(col_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        if (fill_done) state_d = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.command == tcw_pkg::CMD_READ) begin
            state_d = rd_in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_DONE;
          end else begin
            state_d = need_scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
          end
        end
      end
      tcw_pkg::ST_READ: begin
        state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_SCROLL: begin
        if (scan_done && !pend_q) state_d = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        if (fill_done) state_d = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (out_free) state_d = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_addr;
    ram_wdata_o = {text_color_i, in_req_i.char_code};
    ram_re_o    = 1'b0;
    ram_raddr_o = rd_in_addr;
    in_ready_o  = 1'b0;
    ptr_d       = ptr_q;
    wr_addr_d   = wr_addr_q;
    pend_d      = pend_q;
    row_d       = row_q;
    col_d       = col_q;
    cell_d      = cell_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q[ADDR_W-1:0];
        ram_wdata_o = {tcw_pkg::BLANK_COLOR_RESET, tcw_pkg::SPACE_CODE};
        ptr_d       = ptr_q + CNT_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cell_d = '0;
          ptr_d  = CNT_W'(COLS);
          pend_d = 1'b0;
          if (in_req_i.command == tcw_pkg::CMD_READ) begin
            ram_re_o = rd_in_range;
          end else begin
            ram_we_o = !is_newline;
            if (need_scroll) begin
              row_d = ROW_W'(ROWS - 1);
              col_d = '0;
            end else if (wrap) begin
              row_d = row_q + ROW_W'(1);
              col_d = '0;
            end else begin
              col_d = col_q + COL_W'(1);
            end
          end
        end
      end
      tcw_pkg::ST_READ: begin
        cell_d = ram_rdata_i;
      end
      tcw_pkg::ST_SCROLL: begin
        // write back the cell read last cycle one row higher
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = wr_addr_q;
          ram_wdata_o = ram_rdata_i;
        end
        if (!scan_done) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q[ADDR_W-1:0];
          wr_addr_d   = ptr_q[ADDR_W-1:0] - ADDR_W'(COLS);
          ptr_d       = ptr_q + CNT_W'(1);
          pend_d      = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) ptr_d = CNT_W'((ROWS - 1) * COLS);
        end
      end
      tcw_pkg::ST_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q[ADDR_W-1:0];
        ram_wdata_o = {blank_color_i, tcw_pkg::SPACE_CODE};
        ptr_d       = ptr_q + CNT_W'(1);
      end
      tcw_pkg::ST_DONE: begin
        if (out_free) begin
          out_d.cell_char  = cell_q[7:0];
          out_d.cell_attr  = cell_q[15:8];
          out_d.cursor_row = row_ext[tcw_pkg::IN_ROW_W-1:0];
          out_d.cursor_col = col_ext[tcw_pkg::IN_COL_W-1:0];
          out_valid_d      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_CLEAR;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    cell_q    <= cell_d;
    out_q     <= out_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_req_o          = out_q;
  assign status_o.clearing  = (state_q == tcw_pkg::ST_CLEAR);
  assign status_o.scrolling = (state_q == tcw_pkg::ST_SCROLL);
  assign status_o.filling   = (state_q == tcw_pkg::ST_FILL);

endmodule

`default_nettype wire

### rtl/text_console_writer_top.sv
// top level of the text console writer: configuration registers, sequencer
// and screen store; uses tcw_pkg, tcw_ctrl, tcw_screen_ram and the macro header
`default_nettype none

// Text-mode console holding a SCREEN_ROWS x SCREEN_COLUMNS store of 16-bit
// cells (attribute in the high byte, character in the low byte) and a cursor.
// A put request writes its character with text_color at the cursor and
// advances it; newline (10) goes to column 0 of the next row. Passing the
// last row scrolls the screen up one row and blanks the last row with
// blank_color. A read request returns one cell (zero outside the screen).
// Each request gives exactly one result carrying the cursor afterwards.
// One request is worked on at a time, all through a store with one write
// port and one registered read port:
// a put goes from idle to the result state, an in-range read passes
// through a read state for the registered read data, and a put that
// scrolls copies the screen up one row, one cell per cycle, and then
// fills the last row one cell per cycle. After reset a clearing pass
// writes every cell to a space in color 7, during which no request is
// taken; configuration writes are taken at any time.
// The output register lets the next request enter while a result waits.

`include "text_console_writer_top_macros.svh"

module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tcw_pkg::tcw_in_t              in_req_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output tcw_pkg::tcw_out_t                  out_req_o,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [tcw_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // color registers; the blank color is used by the scroll fill, not by the clearing pass
  logic [tcw_pkg::CFG_W-1:0] text_color_q, blank_color_q;

  // store port between sequencer and memory
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  tcw_pkg::tcw_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q  <= tcw_pkg::TEXT_COLOR_RESET;
      blank_color_q <= tcw_pkg::BLANK_COLOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcw_pkg::REG_TEXT_COLOR:  text_color_q  <= cfg_wdata_i;
        tcw_pkg::REG_BLANK_COLOR: blank_color_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // cursor, command handling and the scroll / fill / clear sweeps
  tcw_ctrl #(
    .COLS (SCREEN_COLUMNS),
    .ROWS (SCREEN_ROWS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_req_o     (out_req_o),
    .text_color_i  (text_color_q),
    .blank_color_i (blank_color_q),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .status_o      (status)
  );

  // screen store, one cell per address, row-major
  tcw_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .DATA_W (tcw_pkg::CELL_W)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // only one request in flight: in the cycle after one is taken the input is closed
  `TCW_ASSERT(a_one_request, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  // nothing enters or leaves while the store is being cleared
  `TCW_ASSERT_NEVER(a_clear_quiet, clk_i, rst_ni, status.clearing && (in_ready_o || out_valid_o))
  // the scroll copy always hands over to the last-row fill
  `TCW_ASSERT(a_scroll_fill, clk_i, rst_ni, $fell(status.scrolling) |-> status.filling)

endmodule

`default_nettype wire
